@@ rtl/core/hla_pkg.sv @@
// Shared types and constants for the HSL lightness adjust core.
// No dependencies.
package hla_pkg;

	localparam int DIV_STAGES  = 8;
	localparam int RECIP_SHIFT = 34;
	localparam logic [21:0] RECIP_M = 22'd2245735; // ceil(2^34 / 7650)

	typedef struct packed {
		logic [15:0] num;
		logic [7:0]  den;
	} div_lane_t;

	typedef struct packed {
		logic [7:0] ladj;
		logic       grey;
	} hla_side_t;

endpackage

@@ rtl/core/hla_div.sv @@
// Two-lane restoring divider, one quotient bit per pipeline stage.
// Depends on hla_pkg.
module hla_div import hla_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  div_lane_t  lane_a,
	input  div_lane_t  lane_b,
	input  hla_side_t  side_in,
	output logic       out_valid,
	output logic [7:0] quo_a,
	output logic [7:0] quo_b,
	output hla_side_t  side_out
);

	logic [DIV_STAGES:0] vld;
	logic [15:0] rem_a [DIV_STAGES+1];
	logic [15:0] rem_b [DIV_STAGES+1];
	logic [7:0]  den_a [DIV_STAGES+1];
	logic [7:0]  den_b [DIV_STAGES+1];
	logic [7:0]  qa    [DIV_STAGES+1];
	logic [7:0]  qb    [DIV_STAGES+1];
	hla_side_t   side  [DIV_STAGES+1];

	always_comb begin
		vld[0]   = in_valid;
		rem_a[0] = lane_a.num;
		rem_b[0] = lane_b.num;
		den_a[0] = lane_a.den;
		den_b[0] = lane_b.den;
		qa[0]    = 8'd0;
		qb[0]    = 8'd0;
		side[0]  = side_in;
	end

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [15:0] trial_a, trial_b;
		logic        take_a, take_b;
		always_comb begin
			trial_a = 16'(den_a[i]) << (DIV_STAGES - 1 - i);
			trial_b = 16'(den_b[i]) << (DIV_STAGES - 1 - i);
			take_a  = rem_a[i] >= trial_a;
			take_b  = rem_b[i] >= trial_b;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[i+1] <= 1'b0;
			end else begin
				vld[i+1] <= vld[i];
			end
		end
		always_ff @(posedge clk) begin
			rem_a[i+1] <= take_a ? rem_a[i] - trial_a : rem_a[i];
			rem_b[i+1] <= take_b ? rem_b[i] - trial_b : rem_b[i];
			den_a[i+1] <= den_a[i];
			den_b[i+1] <= den_b[i];
			qa[i+1]    <= {qa[i][6:0], take_a};
			qb[i+1]    <= {qb[i][6:0], take_b};
			side[i+1]  <= side[i];
		end
	end

	assign out_valid = vld[DIV_STAGES];
	assign quo_a     = qa[DIV_STAGES];
	assign quo_b     = qb[DIV_STAGES];
	assign side_out  = side[DIV_STAGES];

endmodule

@@ rtl/core/hsl_lightness_adjust_core.sv @@
// Top level of the HSL lightness adjust core: RGB -> HSL, lightness offset, HSL -> RGB.
// Depends on hla_pkg and hla_div.
//
//  channel   | signals                                   | transfer when
//  ----------+-------------------------------------------+------------------------
//  pixel in  | start, busy, red_in, green_in, blue_in    | start high, busy low
//  pixel out | done, red_out, green_out, blue_out        | done high (one cycle)
//  config    | lightness_offset_we, lightness_offset     | lightness_offset_we high
//
// One pixel enters every cycle; busy is never raised. The pipeline stages are
// one forward stage, eight divider stages (hue and saturation in parallel),
// then the p/q stage, the channel numerator stage and the reciprocal stage.
// Reset clears the valid bits and the offset register. The receiver cannot
// stall, so results leave on done without any holding stage.
module hsl_lightness_adjust_core import hla_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [7:0]        red_in,
	input  logic [7:0]        green_in,
	input  logic [7:0]        blue_in,
	input  logic              lightness_offset_we,
	input  logic signed [8:0] lightness_offset,
	output logic              done,
	output logic [7:0]        red_out,
	output logic [7:0]        green_out,
	output logic [7:0]        blue_out
);

	// Blend weight of a hue position: ramp up, flat top, ramp down, flat bottom.
	function automatic logic [4:0] blend_coef(input logic [7:0] t);
		logic [7:0] c;
		if (t < 8'd30)       c = t;
		else if (t < 8'd90)  c = 8'd30;
		else if (t < 8'd120) c = 8'd120 - t;
		else                 c = 8'd0;
		return c[4:0];
	endfunction

	logic signed [8:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 9'sd0;
		end else if (lightness_offset_we) begin
			offset_q <= lightness_offset;
		end
	end

	assign busy = 1'b0;

	// Forward conversion
	logic [7:0]  mx, mn, d, den;
	logic [8:0]  sum;
	logic signed [17:0] hnum_wide;
	logic signed [10:0] l_sum;
	logic [7:0]  l_adj;
	logic        valid_s1;
	div_lane_t   hue_s1, sat_s1;
	hla_side_t   side_s1;

	always_comb begin
		mx = red_in;
		if (green_in > mx) mx = green_in;
		if (blue_in > mx)  mx = blue_in;
		mn = red_in;
		if (green_in < mn) mn = green_in;
		if (blue_in < mn)  mn = blue_in;
		d   = mx - mn;
		sum = 9'(mx) + 9'(mn);
		den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
		if (red_in == mx) begin
			hnum_wide = 18'sd30 * (18'(signed'({1'b0, green_in})) - 18'(signed'({1'b0, blue_in})));
			if (hnum_wide < 0) hnum_wide = hnum_wide + 18'sd180 * 18'(signed'({1'b0, d}));
		end else if (green_in == mx) begin
			hnum_wide = 18'sd30 * (18'(signed'({1'b0, blue_in})) - 18'(signed'({1'b0, red_in})))
				+ 18'sd60 * 18'(signed'({1'b0, d}));
		end else begin
			hnum_wide = 18'sd30 * (18'(signed'({1'b0, red_in})) - 18'(signed'({1'b0, green_in})))
				+ 18'sd120 * 18'(signed'({1'b0, d}));
		end
		// clamp the adjusted lightness to 0..255
		l_sum = 11'(signed'({1'b0, sum[8:1]})) + 11'(offset_q);
		if (l_sum < 0)              l_adj = 8'd0;
		else if (l_sum > 11'sd255)  l_adj = 8'd255;
		else                        l_adj = l_sum[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		hue_s1.num   <= hnum_wide[15:0];
		hue_s1.den   <= d;
		sat_s1.num   <= 16'(d) * 16'd255;
		sat_s1.den   <= den;
		side_s1.ladj <= l_adj;
		side_s1.grey <= (d == 8'd0);
	end

	// Hue and saturation division
	logic       valid_dv;
	logic [7:0] hue_dv, sat_dv;
	hla_side_t  side_dv;

	hla_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.lane_a    (hue_s1),
		.lane_b    (sat_s1),
		.side_in   (side_s1),
		.out_valid (valid_dv),
		.quo_a     (hue_dv),
		.quo_b     (sat_dv),
		.side_out  (side_dv)
	);

	// p and q numerators over 65025, and hue positions of the three channels
	logic [17:0] qn, pn;
	logic [15:0] ls;
	logic [7:0]  l, t_r, t_b;
	logic [15:0] pn_s10, diff_s10;
	logic [4:0]  c_s10 [3];
	hla_side_t   side_s10;
	logic        valid_s10;

	always_comb begin
		l  = side_dv.ladj;
		ls = 16'(l) * 16'(sat_dv);
		if (l <= 8'd127) qn = 18'(l) * (18'd255 + 18'(sat_dv));
		else             qn = 18'(l) * 18'd255 + 18'(sat_dv) * 18'd255 - 18'(ls);
		pn  = 18'(l) * 18'd510 - qn;
		t_r = (hue_dv >= 8'd121) ? hue_dv - 8'd120 : hue_dv + 8'd60;
		t_b = (hue_dv < 8'd60) ? hue_dv + 8'd120 : hue_dv - 8'd60;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else begin
			valid_s10 <= valid_dv;
		end
	end

	always_ff @(posedge clk) begin
		pn_s10   <= pn[15:0];
		diff_s10 <= 16'(qn - pn);
		c_s10[0] <= blend_coef(t_r);
		c_s10[1] <= blend_coef(hue_dv);
		c_s10[2] <= blend_coef(t_b);
		side_s10 <= side_dv;
	end

	// Channel numerators over 7650
	logic [20:0] num_s11 [3];
	hla_side_t   side_s11;
	logic        valid_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else begin
			valid_s11 <= valid_s10;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			num_s11[k] <= 21'(pn_s10) * 21'd30 + 21'(diff_s10) * 21'(c_s10[k]);
		end
		side_s11 <= side_s10;
	end

	// Divide by 7650 through the reciprocal; a grey pixel takes the lightness
	logic [42:0] prod [3];
	logic [7:0]  ch_s12 [3];
	logic        valid_s12;
	logic        grey_s12;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = 43'(num_s11[k]) * 43'(RECIP_M);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else begin
			valid_s12 <= valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			ch_s12[k] <= side_s11.grey ? side_s11.ladj
				: prod[k][RECIP_SHIFT+7:RECIP_SHIFT];
		end
		grey_s12 <= side_s11.grey;
	end

	assign done      = valid_s12;
	assign red_out   = ch_s12[0];
	assign green_out = ch_s12[1];
	assign blue_out  = ch_s12[2];

	// Checks
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s10 |=> valid_s11 ##1 done)
		else $error("pixel lost in the back end");

	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(done && grey_s12) |-> (red_out == green_out && green_out == blue_out))
		else $error("grey pixel has unequal channels");

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s10 |-> (c_s10[0] <= 5'd30 && c_s10[1] <= 5'd30 && c_s10[2] <= 5'd30))
		else $error("blend weight out of range");

endmodule

@@ tb/tb_hsl_lightness_adjust_core.sv @@
// Self-checking testbench for the HSL lightness adjust core.
// Depends on hla_pkg and hsl_lightness_adjust_core; predicts most pixels in integer arithmetic.
// Stimulus: a directed pixel table first, then random pixels across offset settings.
`timescale 1ns / 1ps

module tb_hsl_lightness_adjust_core;
	import hla_pkg::*;

	localparam int LATENCY    = 12;
	localparam int N_RANDOM   = 1300;
	localparam int MAX_REPORT = 10;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// One row of the directed table: input pixel and, where it is obvious, the result
	typedef struct {
		pixel_t pix;
		bit     known;
		pixel_t res;
	} pixel_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [7:0]        red_in;
	logic [7:0]        green_in;
	logic [7:0]        blue_in;
	logic              lightness_offset_we;
	logic signed [8:0] lightness_offset;
	logic              done;
	logic [7:0]        red_out;
	logic [7:0]        green_out;
	logic [7:0]        blue_out;

	// Offset as seen by the predictor; it only changes while the pipe is empty
	int     offset_now;
	pixel_t pending_pixels[$];
	int     mismatches;
	bit     timed_out;

	hsl_lightness_adjust_core i_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.red_in              (red_in),
		.green_in            (green_in),
		.blue_in             (blue_in),
		.lightness_offset_we (lightness_offset_we),
		.lightness_offset    (lightness_offset),
		.done                (done),
		.red_out             (red_out),
		.green_out           (green_out),
		.blue_out            (blue_out)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Channel value from p and q numerators (over 65025) at a hue position in 1/180 turns
	function automatic int hue_to_channel(int pn, int qn, int t);
		int num;
		if (t < 0)
			t += 180;
		// a position of exactly one turn is left alone and yields p
		if (t > 180)
			t -= 180;
		if (t < 30)
			num = 30 * pn + (qn - pn) * t;
		else if (t < 90)
			num = 30 * qn;
		else if (t < 120)
			num = 30 * pn + (qn - pn) * (120 - t);
		else
			num = 30 * pn;
		return num / (30 * 255);
	endfunction

	// Forward to HSL, add the offset with clamp, and back to RGB
	function automatic pixel_t adjust_lightness(pixel_t pix, int offset);
		int r, g, b, mx, mn, d, h, s, l, den, num, qn, pn;
		pixel_t res;
		r = pix.red;
		g = pix.green;
		b = pix.blue;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		l = (mx + mn) / 2;
		h = 0;
		s = 0;
		if (d != 0) begin
			den = (mx + mn <= 255) ? mx + mn : 510 - mx - mn;
			// ties on the maximum: red first, then green
			if (r == mx) begin
				num = 30 * (g - b);
				if (num < 0)
					num += 180 * d;
				h = num / d;
			end else if (g == mx) begin
				h = (30 * (b - r) + 60 * d) / d;
			end else begin
				h = (30 * (r - g) + 120 * d) / d;
			end
			s = (255 * d) / den;
		end
		l += offset;
		if (l < 0) l = 0;
		if (l > 255) l = 255;
		if (s == 0) begin
			res = '{l[7:0], l[7:0], l[7:0]};
		end else begin
			if (l <= 127)
				qn = l * (255 + s);
			else
				qn = 255 * l + 255 * s - l * s;
			pn = 510 * l - qn;
			res.red   = 8'(hue_to_channel(pn, qn, h + 60));
			res.green = 8'(hue_to_channel(pn, qn, h));
			res.blue  = 8'(hue_to_channel(pn, qn, h - 60));
		end
		return res;
	endfunction

	// Random gap: mostly none or short, now and then long
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55) return 0;
		if (sel < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive one pixel and hold start until the transfer; queue its expectation
	task automatic send_pixel(pixel_t pix, bit known, pixel_t res);
		red_in   <= pix.red;
		green_in <= pix.green;
		blue_in  <= pix.blue;
		start    <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_pixels.push_back(known ? res : adjust_lightness(pix, offset_now));
	endtask

	// Drop start for a random gap, or keep it high when the gap is zero
	task automatic idle_sender();
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait for the pipe to empty, then the latency, then write the offset register
	task automatic write_offset(logic signed [8:0] value);
		start <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		lightness_offset    <= value;
		lightness_offset_we <= 1'b1;
		@(posedge clk);
		lightness_offset_we <= 1'b0;
		offset_now = int'(value);
	endtask

	// Check every strobed result against the oldest expectation
	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n && done) begin
			got = '{red_out, green_out, blue_out};
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORT)
					$display("unexpected result %h", got);
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORT)
						$display("result mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							want.red, want.green, want.blue, got.red, got.green, got.blue);
				end
			end
		end
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#2000000;
		timed_out = 1'b1;
		$display("Verification failed");
		$finish;
	end

	initial begin
		pixel_row_t directed[$];
		int offsets[$];
		int n, sel, base;
		pixel_t pix;
		pixel_t none;

		none                = '0;
		mismatches          = 0;
		timed_out           = 1'b0;
		offset_now          = 0;
		arst_n              = 1'b0;
		start               = 1'b0;
		red_in              = '0;
		green_in            = '0;
		blue_in             = '0;
		lightness_offset_we = 1'b0;
		lightness_offset    = '0;

		// Greys and extremes are typed in; the rest go through the predictor
		directed = '{
			'{'{8'd0,   8'd0,   8'd0},   1, '{8'd0,   8'd0,   8'd0}},
			'{'{8'd255, 8'd255, 8'd255}, 1, '{8'd255, 8'd255, 8'd255}},
			'{'{8'd128, 8'd128, 8'd128}, 1, '{8'd128, 8'd128, 8'd128}},
			'{'{8'd255, 8'd0,   8'd0},   0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd0,   8'd255, 8'd0},   0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd0,   8'd0,   8'd255}, 0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd255, 8'd255, 8'd0},   0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd255, 8'd0,   8'd255}, 0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd0,   8'd255, 8'd255}, 0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd200, 8'd10,  8'd90},  0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd200, 8'd90,  8'd10},  0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd40,  8'd220, 8'd40},  0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd1,   8'd0,   8'd0},   0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd255, 8'd254, 8'd254}, 0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd170, 8'd85,  8'd170}, 0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd255, 8'd1,   8'd0},   0, '{8'd0, 8'd0, 8'd0}},
			'{'{8'd127, 8'd128, 8'd0},   0, '{8'd0, 8'd0, 8'd0}}
		};
		offsets = '{0, 255, -255, 1, -1, 100, -100, 37, -256, -64};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at reset offset, then again at the clamp extremes
		for (int pass = 0; pass < 3; pass++) begin
			if (pass == 1) write_offset(9'sd255);
			if (pass == 2) write_offset(-9'sd255);
			foreach (directed[i]) begin
				if (pass == 0) begin
					send_pixel(directed[i].pix, directed[i].known, directed[i].res);
				end else begin
					send_pixel(directed[i].pix, 1'b0, none);
				end
				if (i % 4 == 3) idle_sender();
			end
		end
		// Full white at maximum brightening and black at maximum darkening
		write_offset(9'sd255);
		send_pixel('{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd255, 8'd255});
		write_offset(-9'sd255);
		send_pixel('{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0});

		// Random pixels in phases, one offset per phase
		n = 0;
		foreach (offsets[k]) begin
			write_offset(9'(offsets[k]));
			for (int j = 0; j < N_RANDOM / 10; j++) begin
				sel = $urandom_range(0, 9);
				if (sel < 6) begin
					pix = '{8'($urandom), 8'($urandom), 8'($urandom)};
				end else if (sel < 8) begin
					// near-grey pixels and ties on the maximum
					base = $urandom_range(0, 255);
					pix.red   = 8'(base);
					pix.green = ($urandom_range(0, 1)) ? 8'(base) : 8'($urandom_range(0, 255));
					pix.blue  = ($urandom_range(0, 1)) ? pix.green : 8'($urandom_range(0, 255));
				end else begin
					// corners of the cube with small jitter
					pix.red   = $urandom_range(0, 1) ? 8'($urandom_range(250, 255)) : 8'($urandom_range(0, 5));
					pix.green = $urandom_range(0, 1) ? 8'($urandom_range(250, 255)) : 8'($urandom_range(0, 5));
					pix.blue  = $urandom_range(0, 1) ? 8'($urandom_range(250, 255)) : 8'($urandom_range(0, 5));
				end
				send_pixel(pix, 1'b0, none);
				n++;
				// bursts with no gaps in half the phases
				if (k % 2 == 1) idle_sender();
			end
		end

		// Drain, then allow for the pipeline latency
		start <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		if (mismatches == 0 && pending_pixels.size() == 0 && !timed_out)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/hla_pkg.sv
rtl/core/hla_div.sv
rtl/core/hsl_lightness_adjust_core.sv
tb/tb_hsl_lightness_adjust_core.sv
